// ===== hw/rtl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// shared types and constants for the rewind snapshot ring
// ----------------------------------------------------------------------------
package rsr_pkg;

  localparam int unsigned InW  = 72;
  localparam int unsigned OutW = 80;

  localparam logic [2:0] CMD_FRAME  = 3'd0;
  localparam logic [2:0] CMD_BACK   = 3'd1;
  localparam logic [2:0] CMD_FWD    = 3'd2;
  localparam logic [2:0] CMD_START  = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NO_SNAP   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_MS_SEC   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_DIV, S_STEP, S_READ, S_SCAN, S_FOUND, S_OUT
  } rsr_state_t;

  // slot write port from the controller to the cell row
  typedef struct packed {
    logic        clr;
    logic        we;
    logic [23:0] size;
    logic [31:0] frame;
  } rsr_wr_t;

  // 60 / period for period 1..60
  function automatic logic [5:0] per_ratio(input logic [5:0] p);
    logic [5:0] r;
    r = 6'd1;
    if      (p <= 6'd1)  r = 6'd60;
    else if (p == 6'd2)  r = 6'd30;
    else if (p == 6'd3)  r = 6'd20;
    else if (p == 6'd4)  r = 6'd15;
    else if (p == 6'd5)  r = 6'd12;
    else if (p == 6'd6)  r = 6'd10;
    else if (p == 6'd7)  r = 6'd8;
    else if (p == 6'd8)  r = 6'd7;
    else if (p <= 6'd10) r = 6'd6;
    else if (p <= 6'd12) r = 6'd5;
    else if (p <= 6'd15) r = 6'd4;
    else if (p <= 6'd20) r = 6'd3;
    else if (p <= 6'd30) r = 6'd2;
    return r;
  endfunction

endpackage

// ===== hw/rtl/rsr_cell.sv =====
// ----------------------------------------------------------------------------
// rsr_cell
// one ring slot: descriptor storage, goal compare and search token stage
// ----------------------------------------------------------------------------
module rsr_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  rsr_pkg::rsr_wr_t wr,
  input  logic            sel,
  input  logic [31:0]     goal,
  input  logic            tok_in,
  input  logic            tok_keep,
  output logic            tok_out,
  output logic            hit,
  output logic            valid,
  output logic [23:0]     size,
  output logic [31:0]     frame
);
  import rsr_pkg::*;

  logic        valid_r;
  logic        tok_r;
  logic [23:0] size_r;
  logic [31:0] frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in & tok_keep;
      if (wr.clr) begin
        valid_r <= 1'b0;
      end else if (wr.we && sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && sel) begin
      size_r  <= wr.size;
      frame_r <= wr.frame;
    end
  end

  assign tok_out = tok_r;
  assign hit     = tok_r & valid_r & (frame_r == goal);
  assign valid   = valid_r;
  assign size    = size_r;
  assign frame   = frame_r;

endmodule

// ===== hw/rtl/rewind_snapshot_ring_top.sv =====
// ----------------------------------------------------------------------------
// rewind_snapshot_ring_top
// ring of snapshot descriptors with step, capture and timed rewind effect
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one command per transfer (frame, step back, step forward,
//   start effect, cancel, tick, clear); out_* returns exactly one result per
//   command. cfg_* writes capacity, capture period and effect ms per second
//   while the block is idle; a capacity write empties the ring.
// command flow:
//   one command at a time. a frame command runs a bit-serial remainder of
//   the frame counter by the capture period. a tick that ends the effect
//   sends a search token down the row of slot cells, one cell per cycle.
// stall:
//   a result sits in the output register until out_tready; the next command
//   is already taken and worked on, and its result waits in the controller.
// reset:
//   synchronous, active low; the ring is empty, registers return to
//   capacity 64 (or MAX_SLOTS if smaller), period 1, 2000 ms per second.
// ----------------------------------------------------------------------------
module rewind_snapshot_ring_top #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata: cmd[2:0], snap_size[26:3], rewind_secs[34:27], now_ms[66:35]
  input  logic [rsr_pkg::InW-1:0]  in_tdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // out_tdata: status[1:0], slot_index[7:2], out_size[31:8],
  // snap_frame[63:32], captured[64], effect_done[65],
  // snapshot_count[72:66], effect_running[73]
  output logic [rsr_pkg::OutW-1:0] out_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [13:0]              cfg_data
);
  import rsr_pkg::*;

  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SW = (CW > 10) ? CW : 10;
  localparam int unsigned CapReset = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  // configuration
  logic [CW-1:0] cap_r;
  logic [5:0]    per_r;
  logic [13:0]   msps_r;

  // ring state
  logic [IW-1:0] head_r, tail_r, idx_r;
  logic [CW-1:0] vc_r, cnt_r;
  logic [31:0]   fc_r;
  logic          eff_r;
  logic [31:0]   eff_start_r, eff_len_r, goal_r;

  // command in flight
  rsr_state_t  state_r, state_nxt;
  logic [2:0]  cmd_r;
  logic [23:0] size_r;
  logic [3:0]  secs_r;
  logic [31:0] now_r;
  logic [SW-1:0] steps_r;
  logic [16:0] len_r;
  logic [31:0] div_r;
  logic [5:0]  rem_r;
  logic [4:0]  bit_r;

  // pending result
  logic [1:0]    res_status_r;
  logic [IW-1:0] res_slot_r;
  logic [23:0]   res_size_r;
  logic [31:0]   res_frame_r;
  logic          res_cap_r, res_done_r;

  logic [OutW-1:0] out_tdata_r;
  logic            out_tvalid_r;

  // cell row
  rsr_wr_t           wr;
  logic [MAX_SLOTS:0] tok;
  logic [MAX_SLOTS-1:0] hit, cvalid;
  logic [23:0] csize  [MAX_SLOTS];
  logic [31:0] cframe [MAX_SLOTS];
  logic        tok_keep, scan_go;

  // controller decode
  logic        accept, out_free;
  logic [IW-1:0] prev_head, next_head, next_tail;
  logic [3:0]  secs_c;
  logic [6:0]  rem_sh;
  logic        tick_due;
  logic [SW-1:0] steps_lim, steps_mod;
  logic [IW-1:0] start_idx;
  logic [CW-1:0] re_vc;
  logic [6:0]  cfg_cap7;

  assign accept   = in_tvalid & in_tready;
  assign out_free = ~out_tvalid_r | out_tready;

  assign prev_head = (head_r == '0) ? IW'(cap_r - 1'b1) : IW'(head_r - 1'b1);
  assign next_head = (CW'(head_r) + 1'b1 == cap_r) ? '0 : IW'(head_r + 1'b1);
  assign next_tail = (CW'(tail_r) + 1'b1 == cap_r) ? '0 : IW'(tail_r + 1'b1);
  assign secs_c    = (in_tdata[34:27] > 8'd10) ? 4'd10 :
                     (in_tdata[34:27] == 8'd0) ? 4'd1 : in_tdata[30:27];
  assign rem_sh    = {rem_r, div_r[31]};
  assign tick_due  = (now_r - eff_start_r) >= eff_len_r;
  assign steps_lim = (steps_r > SW'(vc_r)) ? SW'(vc_r) : steps_r;
  assign steps_mod = (steps_lim == SW'(cap_r)) ? '0 : steps_lim;
  assign start_idx = (SW'(head_r) >= steps_mod) ? IW'(SW'(head_r) - steps_mod)
                                                : IW'(SW'(head_r) + SW'(cap_r) - steps_mod);
  assign re_vc     = (idx_r >= tail_r) ? CW'(CW'(idx_r) - CW'(tail_r) + 1'b1)
                                       : CW'(cap_r - CW'(tail_r) + CW'(idx_r) + 1'b1);
  assign cfg_cap7  = (cfg_data[6:0] == 7'd0) ? 7'd1 : cfg_data[6:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CALC;
      S_CALC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_FRAME: if (size_r != '0) state_nxt = S_DIV;
          CMD_BACK:  if (vc_r != '0) state_nxt = S_READ;
          CMD_FWD:   state_nxt = S_READ;
          CMD_START: if (!eff_r && vc_r != '0) state_nxt = S_STEP;
          CMD_TICK:  if (eff_r && tick_due) state_nxt = S_SCAN;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_DIV:   if (bit_r == 5'd31) state_nxt = S_OUT;
      S_STEP:  state_nxt = S_READ;
      S_READ:  state_nxt = S_OUT;
      S_SCAN: begin
        if (cnt_r == cap_r) state_nxt = S_OUT;
        else if (|hit) state_nxt = S_FOUND;
      end
      S_FOUND: state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and cell control
  always_comb begin
    in_tready = (state_r == S_IDLE);
    scan_go   = (state_r == S_CALC) && (state_nxt == S_SCAN);
    tok_keep  = (state_nxt == S_SCAN);
    wr.clr    = (cfg_we && cfg_index == REG_CAPACITY) ||
                (state_r == S_CALC && cmd_r == CMD_CLEAR);
    wr.we     = (state_r == S_DIV) && (bit_r == 5'd31) && (rem_sh < 7'(per_r) ?
                 (rem_sh == '0) : (rem_sh == 7'(per_r)));
    wr.size   = size_r;
    wr.frame  = fc_r;
  end

  assign tok[0] = scan_go;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    rsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr       (wr),
      .sel      (head_r == IW'(g)),
      .goal     (goal_r),
      .tok_in   (tok[g]),
      .tok_keep (tok_keep),
      .tok_out  (tok[g+1]),
      .hit      (hit[g]),
      .valid    (cvalid[g]),
      .size     (csize[g]),
      .frame    (cframe[g])
    );
  end

  // controller datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CW'(CapReset);
      per_r        <= 6'd1;
      msps_r       <= 14'd2000;
      head_r       <= '0;
      tail_r       <= '0;
      vc_r         <= '0;
      fc_r         <= '0;
      eff_r        <= 1'b0;
      eff_start_r  <= '0;
      eff_len_r    <= '0;
      goal_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a new result or drop the one just taken
      if (state_r == S_OUT && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;

      // configuration writes, only while idle: the user must keep to this, the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: begin
            cap_r  <= (32'(cfg_cap7) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_cap7);
            head_r <= '0;
            tail_r <= '0;
            vc_r   <= '0;
            eff_r  <= 1'b0;
            fc_r   <= '0;
          end
          REG_PERIOD: per_r <= (cfg_data[5:0] == 6'd0) ? 6'd1 :
                               (cfg_data[5:0] > 6'd60) ? 6'd60 : cfg_data[5:0];
          REG_MS_SEC: msps_r <= (cfg_data < 14'd1000) ? 14'd1000 :
                                (cfg_data > 14'd10000) ? 14'd10000 : cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r        <= in_tdata[2:0];
            size_r       <= in_tdata[26:3];
            secs_r       <= secs_c;
            now_r        <= in_tdata[66:35];
            res_status_r <= ST_OK;
            res_slot_r   <= '0;
            res_size_r   <= '0;
            res_frame_r  <= '0;
            res_cap_r    <= 1'b0;
            res_done_r   <= 1'b0;
          end
        end
        S_CALC: begin
          steps_r <= SW'(secs_r) * SW'(per_ratio(per_r));
          len_r   <= 17'(secs_r) * 17'(msps_r);
          div_r   <= fc_r + 1'b1;
          rem_r   <= '0;
          bit_r   <= '0;
          cnt_r   <= '0;
          case (cmd_r)
            CMD_FRAME: begin
              if (size_r == '0) res_status_r <= ST_INVALID;
              else fc_r <= fc_r + 1'b1;
            end
            CMD_BACK: begin
              if (vc_r == '0) res_status_r <= ST_NO_SNAP;
              idx_r <= prev_head;
            end
            CMD_FWD:   idx_r <= next_head;
            CMD_START: begin
              if (eff_r) res_status_r <= ST_INVALID;
              else if (vc_r == '0) res_status_r <= ST_NO_SNAP;
            end
            CMD_CANCEL: eff_r <= 1'b0;
            CMD_TICK:   ;
            CMD_CLEAR: begin
              head_r <= '0;
              tail_r <= '0;
              vc_r   <= '0;
              eff_r  <= 1'b0;
            end
            default: res_status_r <= ST_INVALID;
          endcase
        end
        S_DIV: begin
          div_r <= {div_r[30:0], 1'b0};
          bit_r <= bit_r + 1'b1;
          rem_r <= (rem_sh >= 7'(per_r)) ? 6'(rem_sh - 7'(per_r)) : rem_sh[5:0];
          if (wr.we) begin
            res_slot_r  <= head_r;
            res_size_r  <= size_r;
            res_frame_r <= fc_r;
            res_cap_r   <= 1'b1;
            head_r      <= next_head;
            if (vc_r < cap_r) vc_r <= vc_r + 1'b1;
            else tail_r <= next_tail;
          end
        end
        S_STEP: idx_r <= start_idx;
        S_READ: begin
          if (cmd_r == CMD_START) begin
            eff_r       <= 1'b1;
            eff_start_r <= now_r;
            eff_len_r   <= 32'(len_r);
            goal_r      <= cframe[idx_r];
            res_slot_r  <= idx_r;
            res_size_r  <= csize[idx_r];
            res_frame_r <= cframe[idx_r];
          end else if (!cvalid[idx_r]) begin
            res_status_r <= (cmd_r == CMD_BACK) ? ST_INVALID : ST_NO_SNAP;
          end else begin
            res_slot_r  <= idx_r;
            res_size_r  <= csize[idx_r];
            res_frame_r <= cframe[idx_r];
            head_r      <= idx_r;
            if (cmd_r == CMD_BACK) vc_r <= vc_r - 1'b1;
            else if (vc_r < cap_r) vc_r <= vc_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (cnt_r == cap_r) begin
            eff_r        <= 1'b0;
            res_status_r <= ST_NOT_FOUND;
          end else if (|hit) begin
            idx_r <= IW'(cnt_r);
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FOUND: begin
          eff_r       <= 1'b0;
          res_slot_r  <= idx_r;
          res_size_r  <= csize[idx_r];
          res_frame_r <= cframe[idx_r];
          res_done_r  <= 1'b1;
          head_r      <= idx_r;
          vc_r        <= re_vc;
        end
        S_OUT: begin
          if (out_free) begin
            out_tdata_r  <= {6'd0, eff_r, 7'(vc_r), res_done_r, res_cap_r,
                             res_frame_r, res_size_r, 6'(res_slot_r), res_status_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

endmodule

// ===== hw/rtl/rsr_checker.sv =====
// ----------------------------------------------------------------------------
// rsr_checker
// port-level checks for the rewind snapshot ring
// ----------------------------------------------------------------------------
module rsr_prop_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [rsr_pkg::OutW-1:0] out_tdata,
  input logic                     out_tvalid,
  input logic                     out_tready
);
  import rsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");

  a_cap_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[1:0] == ST_OK && !out_tdata[65])
    else $error("capture with bad status");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> !out_tdata[73] && out_tdata[1:0] == ST_OK)
    else $error("effect still running after done");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");

endmodule

bind rewind_snapshot_ring_top rsr_prop_checker u_rsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
